>>> rtl/video_frame_pacer_macros.svh
// Assertion macros shared by the frame pacer modules.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef VIDEO_FRAME_PACER_MACROS_SVH
`define VIDEO_FRAME_PACER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VFP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame pacer check failed: %m");

// Next-cycle implication, checked outside reset.
`define VFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame pacer check failed: %m");

`endif

>>> rtl/vfp_pkg.sv
// Shared types and constants of the video frame pacer.
// No dependencies; imported by every module of the block.
package vfp_pkg;

    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 20;
    localparam int BUF_W    = 4;
    localparam int GEN_W    = 16;
    localparam int ALU_W    = TIME_W + 2;
    localparam int CNT_W    = $clog2(TIME_W + 1);

    localparam int US_PER_S     = 1000000;
    localparam int FALLBACK_FPS = 60;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(16667);
    localparam logic [PERIOD_W-1:0] PERIOD_FALLBACK = PERIOD_W'(US_PER_S / FALLBACK_FPS);
    localparam logic [TIME_W-1:0]   TIME_MAX        = '1;

    localparam logic [1:0] ACT_RELEASE = 2'd0;
    localparam logic [1:0] ACT_FLUSH   = 2'd1;
    localparam logic [1:0] ACT_KEY     = 2'd2;
    localparam logic [1:0] ACT_NORMAL  = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] frame_time;
        logic [TIME_W-1:0] now_time;
        logic [BUF_W-1:0]  frame_buffer;
        logic [GEN_W-1:0]  frame_generation;
        logic [GEN_W-1:0]  slot_generation;
        logic              streaming;
        logic              has_texture;
        logic              needs_key;
        logic              congested;
        logic              fence_ready;
    } t_vfp_in;

    typedef struct packed {
        logic [1:0]        action;
        logic [BUF_W-1:0]  buffer_index;
        logic [TIME_W-1:0] action_time;
        logic              last_of_run;
    } t_vfp_out;

    // Result request from the sequencer to the output stage.
    typedef struct packed {
        logic     emit;
        logic     close;
        t_vfp_out data;
    } t_vfp_emit;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_vfp_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } t_vfp_alu_rsp;

    typedef enum logic [5:0] {
        S_IDLE,
        S_GEN,
        S_FGEN,
        S_FLUSH,
        S_FLUSH_REL,
        S_STRM,
        S_KEY_REL,
        S_KEY,
        S_REL_DONE,
        S_CONG,
        S_CU_SUB,
        S_CU_DIV,
        S_CU_FIX1,
        S_CU_FIX2,
        S_P15,
        S_LATE_A,
        S_LATE_B,
        S_PGEN,
        S_DN1,
        S_DN2,
        S_DP1,
        S_DP2,
        S_DCMP,
        S_REL_NEW,
        S_REPL,
        S_DUE1,
        S_DUE2,
        S_DUE3,
        S_DUE_GEN,
        S_STALE1,
        S_STALE2,
        S_STALE_REL,
        S_STALE_T,
        S_ENC,
        S_ENC_REL,
        S_ENC_CHK1,
        S_ENC_CHK2,
        S_DONE
    } t_vfp_state;

endpackage

>>> rtl/vfp_alu.sv
// Shared add/subtract unit of the frame pacer, one operation per cycle.
// Depends on vfp_pkg for operand width and request/response types.
module vfp_alu
    import vfp_pkg::*;
(
    input  t_vfp_alu_req i_req,
    output t_vfp_alu_rsp o_rsp
);

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W:0]   sum;

    // Subtract as a + ~b + 1; carry out high means a >= b.
    assign b_eff = i_req.sub ? ~i_req.b : i_req.b;
    assign sum   = {1'b0, i_req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, i_req.sub};

    assign o_rsp.res    = sum[ALU_W-1:0];
    assign o_rsp.borrow = i_req.sub & ~sum[ALU_W];

endmodule

>>> rtl/vfp_obuf.sv
// Output stage of the frame pacer: one staging slot plus the output register.
// Depends on vfp_pkg and the assertion macros header.
`include "video_frame_pacer_macros.svh"

module vfp_obuf
    import vfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_vfp_emit i_emit,
    output logic      o_ok,
    output logic      o_out_valid,
    output t_vfp_out  o_out_data,
    input  logic      i_out_stall
);

    logic     r_stg_valid, n_stg_valid;
    t_vfp_out r_stg, n_stg;
    logic     r_out_valid, n_out_valid;
    t_vfp_out r_out, n_out;
    logic     out_free;
    logic     load;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_ok     = !r_stg_valid || out_free;
    // The staged beat moves out when a newer one arrives or the run closes.
    assign load     = (i_emit.emit || i_emit.close) && r_stg_valid && out_free;

    always_comb begin
        n_stg_valid = r_stg_valid;
        n_stg       = r_stg;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (load) begin
            n_out             = r_stg;
            n_out.last_of_run = i_emit.close;
            n_out_valid       = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_emit.emit && o_ok) begin
            n_stg       = i_emit.data;
            n_stg_valid = 1'b1;
        end else if (i_emit.close && o_ok) begin
            n_stg_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_stg_valid <= n_stg_valid;
            r_out_valid <= n_out_valid;
        end
        r_stg <= n_stg;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `VFP_ASSERT_NEXT(a_emit_stages, i_emit.emit && o_ok, r_stg_valid)
    `VFP_ASSERT_NEXT(a_close_empties, i_emit.close && o_ok, !r_stg_valid)
    `VFP_ASSERT_IMPL(a_no_overwrite, r_out_valid && i_out_stall, !load)

endmodule

>>> rtl/vfp_ctrl.sv
// Sequencer of the frame pacer: pacing state, item latch and the step machine
// that drives the shared adder. Depends on vfp_pkg and the assertion macros.
`include "video_frame_pacer_macros.svh"

module vfp_ctrl
    import vfp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  t_vfp_in             i_in_data,
    output logic                o_in_stall,
    input  logic [PERIOD_W-1:0] i_period,
    output t_vfp_alu_req        o_alu_req,
    input  t_vfp_alu_rsp        i_alu_rsp,
    output t_vfp_emit           o_emit,
    input  logic                i_emit_ok
);

    t_vfp_state          r_state, n_state;
    t_vfp_in             r_item, n_item;
    logic [PERIOD_W-1:0] r_p, n_p;
    logic [GEN_W-1:0]    r_last_gen, n_last_gen;
    logic                r_was_strm, n_was_strm;
    logic                r_pend_valid, n_pend_valid;
    logic [TIME_W-1:0]   r_pend_time, n_pend_time;
    logic [BUF_W-1:0]    r_pend_buf, n_pend_buf;
    logic [GEN_W-1:0]    r_pend_gen, n_pend_gen;
    logic [TIME_W-1:0]   r_deadline, n_deadline;
    logic [ALU_W-1:0]    r_tmp, n_tmp;
    logic [TIME_W-1:0]   r_da, n_da;
    logic [TIME_W-1:0]   r_db, n_db;
    logic [TIME_W-1:0]   r_cu_t, n_cu_t;
    logic [TIME_W-1:0]   r_div, n_div;
    logic [PERIOD_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    logic                accept;
    logic                step_ok;
    logic                gen_chg;
    logic                gen_bad;
    logic                pend_gen_bad;
    logic [ALU_W-1:0]    p_x, p_half_x, p_dbl_x;
    logic [ALU_W-1:0]    ts_x, now_x, dl_x, pt_x, cu_x;
    logic [PERIOD_W:0]   trial;

    function automatic logic [TIME_W-1:0] sat_time(input logic [ALU_W-1:0] v);
        logic ovf;
        ovf = |v[ALU_W-1:TIME_W];
        return ovf ? TIME_MAX : v[TIME_W-1:0];
    endfunction

    assign o_in_stall   = (r_state != S_IDLE);
    assign accept       = i_in_valid && !o_in_stall;
    assign step_ok      = !(o_emit.emit || o_emit.close) || i_emit_ok;

    assign gen_chg      = r_item.slot_generation != r_last_gen;
    assign gen_bad      = r_item.frame_generation != r_item.slot_generation;
    assign pend_gen_bad = r_pend_gen != r_item.slot_generation;

    assign p_x      = ALU_W'(r_p);
    assign p_half_x = ALU_W'(r_p >> 1);
    assign p_dbl_x  = ALU_W'({r_p, 1'b0});
    assign ts_x     = ALU_W'(r_item.frame_time);
    assign now_x    = ALU_W'(r_item.now_time);
    assign dl_x     = ALU_W'(r_deadline);
    assign pt_x     = ALU_W'(r_pend_time);
    assign cu_x     = ALU_W'(r_cu_t);
    assign trial    = {r_rem, r_div[TIME_W-1]};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (accept) n_state = S_GEN;
            S_GEN:       if (step_ok) n_state = S_FGEN;
            S_FGEN: begin
                if (step_ok) begin
                    if (gen_bad) begin
                        n_state = S_DONE;
                    end else if (r_item.streaming && !r_was_strm) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_STRM;
                    end
                end
            end
            S_FLUSH:     if (step_ok) n_state = S_FLUSH_REL;
            S_FLUSH_REL: if (step_ok) n_state = S_STRM;
            S_STRM: begin
                if (step_ok) begin
                    if (!r_item.streaming || !r_item.has_texture) begin
                        n_state = S_DONE;
                    end else if (r_item.needs_key) begin
                        n_state = S_KEY_REL;
                    end else if (r_item.congested) begin
                        n_state = S_CONG;
                    end else begin
                        n_state = S_P15;
                    end
                end
            end
            S_KEY_REL:   if (step_ok) n_state = S_KEY;
            S_KEY:       if (step_ok) n_state = S_REL_DONE;
            S_REL_DONE:  if (step_ok) n_state = S_DONE;
            S_CONG:      if (step_ok) n_state = S_CU_SUB;
            S_CU_SUB: begin
                if (!i_alu_rsp.borrow && i_alu_rsp.res != '0) begin
                    n_state = S_CU_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CU_DIV:    if (r_cnt == CNT_W'(1)) n_state = S_CU_FIX1;
            S_CU_FIX1:   n_state = S_CU_FIX2;
            S_CU_FIX2:   n_state = S_DONE;
            S_P15:       n_state = S_LATE_A;
            S_LATE_A:    n_state = S_LATE_B;
            S_LATE_B:    n_state = i_alu_rsp.borrow ? S_REL_DONE : S_PGEN;
            S_PGEN: begin
                if (step_ok) begin
                    n_state = (r_pend_valid && !pend_gen_bad) ? S_DN1 : S_REPL;
                end
            end
            S_DN1:       n_state = i_alu_rsp.borrow ? S_DN2 : S_DP1;
            S_DN2:       n_state = S_DP1;
            S_DP1:       n_state = i_alu_rsp.borrow ? S_DP2 : S_DCMP;
            S_DP2:       n_state = S_DCMP;
            S_DCMP:      n_state = i_alu_rsp.borrow ? S_REPL : S_REL_NEW;
            S_REL_NEW:   if (step_ok) n_state = S_DUE1;
            S_REPL:      if (step_ok) n_state = S_DUE1;
            S_DUE1:      n_state = i_alu_rsp.borrow ? S_DUE2 : S_DUE_GEN;
            S_DUE2:      n_state = S_DUE3;
            S_DUE3:      n_state = i_alu_rsp.borrow ? S_DONE : S_DUE_GEN;
            S_DUE_GEN:   if (step_ok) n_state = pend_gen_bad ? S_DONE : S_STALE1;
            S_STALE1:    n_state = S_STALE2;
            S_STALE2:    n_state = i_alu_rsp.borrow ? S_STALE_REL : S_ENC;
            S_STALE_REL: if (step_ok) n_state = S_STALE_T;
            S_STALE_T:   n_state = i_alu_rsp.borrow ? S_DONE : S_CU_SUB;
            S_ENC:       if (step_ok) n_state = S_ENC_REL;
            S_ENC_REL:   if (step_ok) n_state = S_ENC_CHK1;
            S_ENC_CHK1:  n_state = i_alu_rsp.borrow ? S_DONE : S_ENC_CHK2;
            S_ENC_CHK2:  n_state = S_DONE;
            S_DONE:      if (step_ok) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Adder operands and result beats
    always_comb begin
        o_alu_req                = '0;
        o_emit.emit              = 1'b0;
        o_emit.close             = 1'b0;
        o_emit.data.action       = ACT_RELEASE;
        o_emit.data.buffer_index = r_item.frame_buffer;
        o_emit.data.action_time  = r_item.frame_time;
        o_emit.data.last_of_run  = 1'b0;
        unique case (r_state)
            S_GEN, S_FLUSH_REL, S_KEY_REL, S_PGEN, S_REPL, S_DUE_GEN, S_STALE_REL,
            S_ENC_REL: begin
                o_emit.data.buffer_index = r_pend_buf;
                o_emit.data.action_time  = r_pend_time;
                case (r_state)
                    S_GEN:     o_emit.emit = gen_chg && r_pend_valid;
                    S_PGEN:    o_emit.emit = r_pend_valid && pend_gen_bad;
                    S_DUE_GEN: o_emit.emit = pend_gen_bad;
                    S_STALE_REL, S_ENC_REL: o_emit.emit = 1'b1;
                    default:   o_emit.emit = r_pend_valid;
                endcase
                if (r_state == S_ENC_REL) begin
                    o_alu_req.a = dl_x;
                    o_alu_req.b = p_x;
                end
            end
            S_FGEN:      o_emit.emit = gen_bad;
            S_FLUSH: begin
                o_emit.emit              = 1'b1;
                o_emit.data.action       = ACT_FLUSH;
                o_emit.data.buffer_index = '0;
                o_emit.data.action_time  = '0;
            end
            S_STRM:      o_emit.emit = !r_item.streaming || !r_item.has_texture;
            S_KEY: begin
                o_emit.emit        = r_item.fence_ready;
                o_emit.data.action = ACT_KEY;
                o_alu_req.a        = ts_x;
                o_alu_req.b        = p_x;
            end
            S_REL_DONE, S_CONG, S_REL_NEW: o_emit.emit = 1'b1;
            S_CU_SUB: begin
                o_alu_req.a   = cu_x;
                o_alu_req.b   = dl_x;
                o_alu_req.sub = 1'b1;
            end
            S_CU_DIV: begin
                o_alu_req.a   = ALU_W'(trial);
                o_alu_req.b   = p_x;
                o_alu_req.sub = 1'b1;
            end
            S_CU_FIX1: begin
                o_alu_req.a   = p_x;
                o_alu_req.b   = ALU_W'(r_rem);
                o_alu_req.sub = 1'b1;
            end
            S_CU_FIX2: begin
                o_alu_req.a = cu_x;
                o_alu_req.b = r_tmp;
            end
            S_P15: begin
                o_alu_req.a = p_x;
                o_alu_req.b = p_half_x;
            end
            S_LATE_A: begin
                o_alu_req.a = ts_x;
                o_alu_req.b = r_tmp;
            end
            S_LATE_B: begin
                o_alu_req.a   = r_tmp;
                o_alu_req.b   = dl_x;
                o_alu_req.sub = 1'b1;
            end
            S_DN1: begin
                o_alu_req.a   = ts_x;
                o_alu_req.b   = dl_x;
                o_alu_req.sub = 1'b1;
            end
            S_DN2: begin
                o_alu_req.a   = dl_x;
                o_alu_req.b   = ts_x;
                o_alu_req.sub = 1'b1;
            end
            S_DP1, S_DUE1: begin
                o_alu_req.a   = pt_x;
                o_alu_req.b   = dl_x;
                o_alu_req.sub = 1'b1;
            end
            S_DP2: begin
                o_alu_req.a   = dl_x;
                o_alu_req.b   = pt_x;
                o_alu_req.sub = 1'b1;
            end
            S_DCMP: begin
                o_alu_req.a   = ALU_W'(r_da);
                o_alu_req.b   = ALU_W'(r_db);
                o_alu_req.sub = 1'b1;
            end
            S_DUE2: begin
                o_alu_req.a = dl_x;
                o_alu_req.b = p_half_x;
            end
            S_DUE3: begin
                o_alu_req.a   = now_x;
                o_alu_req.b   = r_tmp;
                o_alu_req.sub = 1'b1;
            end
            S_STALE1: begin
                o_alu_req.a = pt_x;
                o_alu_req.b = p_dbl_x;
            end
            S_STALE2: begin
                o_alu_req.a   = r_tmp;
                o_alu_req.b   = now_x;
                o_alu_req.sub = 1'b1;
            end
            S_STALE_T: begin
                o_alu_req.a   = now_x;
                o_alu_req.b   = p_x;
                o_alu_req.sub = 1'b1;
            end
            S_ENC: begin
                o_emit.emit              = r_item.fence_ready;
                o_emit.data.action       = ACT_NORMAL;
                o_emit.data.buffer_index = r_pend_buf;
                o_emit.data.action_time  = r_pend_time;
            end
            S_ENC_CHK1: begin
                o_alu_req.a   = now_x;
                o_alu_req.b   = p_dbl_x;
                o_alu_req.sub = 1'b1;
            end
            S_ENC_CHK2: begin
                o_alu_req.a   = dl_x;
                o_alu_req.b   = r_tmp;
                o_alu_req.sub = 1'b1;
            end
            S_DONE:      o_emit.close = 1'b1;
            default:     o_alu_req = '0;
        endcase
    end

    // Datapath next values; nothing advances while a result beat waits
    always_comb begin
        n_item       = r_item;
        n_p          = r_p;
        n_last_gen   = r_last_gen;
        n_was_strm   = r_was_strm;
        n_pend_valid = r_pend_valid;
        n_pend_time  = r_pend_time;
        n_pend_buf   = r_pend_buf;
        n_pend_gen   = r_pend_gen;
        n_deadline   = r_deadline;
        n_tmp        = r_tmp;
        n_da         = r_da;
        n_db         = r_db;
        n_cu_t       = r_cu_t;
        n_div        = r_div;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        if (step_ok) begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        n_item = i_in_data;
                        n_p    = i_period;
                    end
                end
                S_GEN: begin
                    if (gen_chg) begin
                        n_pend_valid = 1'b0;
                        n_last_gen   = r_item.slot_generation;
                        n_deadline   = '0;
                    end
                end
                S_FLUSH:     n_deadline = '0;
                S_FLUSH_REL, S_KEY_REL, S_STALE_REL: n_pend_valid = 1'b0;
                S_STRM: begin
                    n_was_strm = r_item.streaming;
                    // A zero deadline counts as unset
                    if (r_item.streaming && r_item.has_texture && r_deadline == '0) begin
                        n_deadline = r_item.frame_time;
                    end
                end
                S_KEY: begin
                    if (r_item.fence_ready) n_deadline = sat_time(i_alu_rsp.res);
                end
                S_CONG:      n_cu_t = r_item.frame_time;
                S_CU_SUB: begin
                    n_div = i_alu_rsp.res[TIME_W-1:0];
                    n_rem = '0;
                    n_cnt = CNT_W'(TIME_W);
                end
                S_CU_DIV: begin
                    // Restoring step: keep the trial remainder when it went negative
                    n_rem = i_alu_rsp.borrow ? trial[PERIOD_W-1:0]
                                             : i_alu_rsp.res[PERIOD_W-1:0];
                    n_div = {r_div[TIME_W-2:0], 1'b0};
                    n_cnt = r_cnt - CNT_W'(1);
                end
                S_CU_FIX1:   n_tmp = (r_rem == '0) ? '0 : i_alu_rsp.res;
                S_CU_FIX2:   n_deadline = sat_time(i_alu_rsp.res);
                S_P15, S_LATE_A, S_DUE2, S_STALE1, S_ENC_CHK1: n_tmp = i_alu_rsp.res;
                S_PGEN: begin
                    if (o_emit.emit) n_pend_valid = 1'b0;
                end
                S_DN1, S_DN2: n_da = i_alu_rsp.res[TIME_W-1:0];
                S_DP1, S_DP2: n_db = i_alu_rsp.res[TIME_W-1:0];
                S_REPL: begin
                    n_pend_valid = 1'b1;
                    n_pend_time  = r_item.frame_time;
                    n_pend_buf   = r_item.frame_buffer;
                    n_pend_gen   = r_item.frame_generation;
                end
                S_DUE_GEN: begin
                    if (pend_gen_bad) n_pend_valid = 1'b0;
                end
                S_STALE_T:   n_cu_t = i_alu_rsp.res[TIME_W-1:0];
                S_ENC_REL: begin
                    n_pend_valid = 1'b0;
                    n_deadline   = sat_time(i_alu_rsp.res);
                end
                S_ENC_CHK2: begin
                    if (i_alu_rsp.borrow) n_deadline = r_item.now_time;
                end
                default: begin
                    n_tmp = r_tmp;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_gen   <= '0;
            r_was_strm   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_time  <= '0;
            r_pend_buf   <= '0;
            r_pend_gen   <= '0;
            r_deadline   <= '0;
        end else begin
            r_state      <= n_state;
            r_last_gen   <= n_last_gen;
            r_was_strm   <= n_was_strm;
            r_pend_valid <= n_pend_valid;
            r_pend_time  <= n_pend_time;
            r_pend_buf   <= n_pend_buf;
            r_pend_gen   <= n_pend_gen;
            r_deadline   <= n_deadline;
        end
        r_item <= n_item;
        r_p    <= n_p;
        r_tmp  <= n_tmp;
        r_da   <= n_da;
        r_db   <= n_db;
        r_cu_t <= n_cu_t;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
    end

    `VFP_ASSERT_IMPL(a_rem_below_p, r_state == S_CU_FIX1, r_rem < r_p)
    `VFP_ASSERT_IMPL(a_div_count_live, r_state == S_CU_DIV, r_cnt != '0)
    `VFP_ASSERT_NEXT(a_repl_holds, r_state == S_REPL && step_ok, r_pend_valid)
    `VFP_ASSERT_NEXT(a_done_to_idle, r_state == S_DONE && step_ok, r_state == S_IDLE)

endmodule

>>> rtl/video_frame_pacer.sv
// Video frame pacer: input channel of captured frames, output channel of
// release/flush/encode beats, and a write channel for the frame period.
//
// Input beats carry one frame with the current time and link flags; an input
// beat is taken when i_in_valid is high and o_in_stall is low. Each frame
// produces zero to four result beats on o_out_*; the final beat of a frame
// has last_of_run set. A result is taken when o_out_valid is high and
// i_out_stall is low.
// The period register (microseconds, zero selects 16666) is written through
// i_cfg_valid/o_cfg_ready; the user must write it only while no frame is
// in flight, as the block itself does not enforce this. One frame holds the
// sequencer for a series of steps, one pass through the single shared
// 50-bit adder per step; when the deadline has to catch up, a 48-step
// remainder loop lengthens the series. Each beat waits in a staging slot
// until the next beat or the end of the frame. The next frame can be taken
// once the last beat of the frame has reached the output register.
// While the receiver stalls, the sequencer holds at its next result beat.
// Reset clears the pacing state, drops any pending frame silently and loads
// the period with 16667.
// Depends on vfp_pkg, vfp_alu, vfp_obuf and vfp_ctrl.
module video_frame_pacer
    import vfp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  t_vfp_in             i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output t_vfp_out            o_out_data,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    input  logic [PERIOD_W-1:0] i_cfg_data,
    output logic                o_cfg_ready
);

    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] period_eff;
    t_vfp_alu_req        alu_req;
    t_vfp_alu_rsp        alu_rsp;
    t_vfp_emit           emit;
    logic                emit_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_period <= i_cfg_data;
        end
    end

    // Fall back to 60 frames per second for a zero period
    assign period_eff = (r_period == '0) ? PERIOD_FALLBACK : r_period;

    vfp_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    vfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_period   (period_eff),
        .o_alu_req  (alu_req),
        .i_alu_rsp  (alu_rsp),
        .o_emit     (emit),
        .i_emit_ok  (emit_ok)
    );

    vfp_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (emit),
        .o_ok        (emit_ok),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
